/* design/rrrb_pkg.sv */
`timescale 1ns / 1ps

package rrrb_pkg;

   localparam int ROB_DEPTH  = 64;
   localparam int ARCH_REGS  = 67;
   localparam int MAX_RETIRE = 8;

   localparam int TAG_W  = 6;
   localparam int REG_W  = 7;
   localparam int SIZE_W = 7;
   localparam int CNT_W  = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] OP_RENAME    = 2'd0;
   localparam logic [1:0] OP_WRITEBACK = 2'd1;
   localparam logic [1:0] OP_RETIRE    = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_READY = 2'd2;

   localparam logic REG_ROB_ENTRIES  = 1'b0;
   localparam logic REG_RETIRE_WIDTH = 1'b1;

   localparam logic [SIZE_W-1:0] ROB_ENTRIES_RESET  = 7'd64;
   localparam logic [CNT_W-1:0]  RETIRE_WIDTH_RESET = 4'd4;

   typedef struct packed {
      logic [1:0]       operation;
      logic             dest_valid;
      logic [REG_W-1:0] dest_areg;
      logic             src1_valid;
      logic [REG_W-1:0] src1_areg;
      logic             src2_valid;
      logic [REG_W-1:0] src2_areg;
      logic [TAG_W-1:0] writeback_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [TAG_W-1:0] entry_tag;
      logic             src1_renamed;
      logic [TAG_W-1:0] src1_ptag;
      logic             src1_rdy;
      logic             src2_renamed;
      logic [TAG_W-1:0] src2_ptag;
      logic             src2_rdy;
      logic             retired_dest_valid;
      logic [REG_W-1:0] retired_dest_areg;
      logic             last;
   } rsp_type;

   // Effective configuration, already clamped to the supported ranges.
   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic [CNT_W-1:0]  width;
      logic              clear;
   } cfg_type;

   typedef struct packed {
      logic             rd_a;
      logic [REG_W-1:0] addr_a;
      logic             rd_b;
      logic [REG_W-1:0] addr_b;
      logic             set;
      logic             clr;
      logic [REG_W-1:0] wr_addr;
      logic [TAG_W-1:0] wr_tag;
   } map_ctl_type;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
   } map_rd_type;

   typedef struct packed {
      logic             rd;
      logic [TAG_W-1:0] rd_addr;
      logic             wr;
      logic [TAG_W-1:0] wr_addr;
      logic             has_dest;
      logic [REG_W-1:0] dest_areg;
      logic             rdy_en;
      logic [TAG_W-1:0] rdy_addr;
      logic             rdy_value;
   } rob_ctl_type;

   typedef struct packed {
      logic             has_dest;
      logic [REG_W-1:0] dest_areg;
   } rob_rd_type;

endpackage

/* design/rrrb_csr.sv */
`timescale 1ns / 1ps

module rrrb_csr
   import rrrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   logic [SIZE_W-1:0] rob_entries_ff;
   logic [CNT_W-1:0]  retire_width_ff;
   logic              wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rob_entries_ff  <= ROB_ENTRIES_RESET;
         retire_width_ff <= RETIRE_WIDTH_RESET;
      end else if (wr_en) begin
         case (csr_paddr[2])
            REG_ROB_ENTRIES: begin
               rob_entries_ff <= csr_pwdata[SIZE_W-1:0];
            end
            REG_RETIRE_WIDTH: begin
               retire_width_ff <= csr_pwdata[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         REG_ROB_ENTRIES: begin
            csr_prdata[SIZE_W-1:0] = rob_entries_ff;
         end
         REG_RETIRE_WIDTH: begin
            csr_prdata[CNT_W-1:0] = retire_width_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (rob_entries_ff == '0) begin
         cfg.size = SIZE_W'(1);
      end else if (rob_entries_ff > SIZE_W'(ROB_DEPTH)) begin
         cfg.size = SIZE_W'(ROB_DEPTH);
      end else begin
         cfg.size = rob_entries_ff;
      end
      if (retire_width_ff == '0) begin
         cfg.width = CNT_W'(1);
      end else if (retire_width_ff > CNT_W'(MAX_RETIRE)) begin
         cfg.width = CNT_W'(MAX_RETIRE);
      end else begin
         cfg.width = retire_width_ff;
      end
      // Resizing the buffer empties it and drops every mapping.
      cfg.clear = wr_en && (csr_paddr[2] == REG_ROB_ENTRIES);
   end

endmodule

/* design/rrrb_map.sv */
`timescale 1ns / 1ps

module rrrb_map
   import rrrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  map_ctl_type ctl,
   output map_rd_type  rd_a,
   output map_rd_type  rd_b
);

   logic [TAG_W-1:0]     map_tag_mem [ARCH_REGS];
   logic [ARCH_REGS-1:0] map_valid_ff;
   map_rd_type           rd_a_ff;
   map_rd_type           rd_b_ff;

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         map_valid_ff <= '0;
      end else if (ctl.set && (ctl.wr_addr < REG_W'(ARCH_REGS))) begin
         map_valid_ff[ctl.wr_addr] <= 1'b1;
      end else if (ctl.clr && (ctl.wr_addr < REG_W'(ARCH_REGS))) begin
         map_valid_ff[ctl.wr_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.set && (ctl.wr_addr < REG_W'(ARCH_REGS))) begin
         map_tag_mem[ctl.wr_addr] <= ctl.wr_tag;
      end
   end

   // Registered read ports; a register number past the map reads as unmapped.
   always_ff @(posedge clock) begin
      if (ctl.rd_a) begin
         if (ctl.addr_a < REG_W'(ARCH_REGS)) begin
            rd_a_ff.valid <= map_valid_ff[ctl.addr_a];
            rd_a_ff.tag   <= map_tag_mem[ctl.addr_a];
         end else begin
            rd_a_ff.valid <= 1'b0;
            rd_a_ff.tag   <= '0;
         end
      end
      if (ctl.rd_b) begin
         if (ctl.addr_b < REG_W'(ARCH_REGS)) begin
            rd_b_ff.valid <= map_valid_ff[ctl.addr_b];
            rd_b_ff.tag   <= map_tag_mem[ctl.addr_b];
         end else begin
            rd_b_ff.valid <= 1'b0;
            rd_b_ff.tag   <= '0;
         end
      end
   end

endmodule

/* design/rrrb_rob.sv */
`timescale 1ns / 1ps

module rrrb_rob
   import rrrb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  rob_ctl_type          ctl,
   output rob_rd_type           rd,
   output logic [ROB_DEPTH-1:0] ready
);

   rob_rd_type           dest_mem [ROB_DEPTH];
   rob_rd_type           rd_ff;
   logic [ROB_DEPTH-1:0] ready_ff;

   assign rd    = rd_ff;
   assign ready = ready_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         dest_mem[ctl.wr_addr] <= '{has_dest: ctl.has_dest, dest_areg: ctl.dest_areg};
      end
      if (ctl.rd) begin
         rd_ff <= dest_mem[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         ready_ff <= '0;
      end else if (ctl.rdy_en) begin
         ready_ff[ctl.rdy_addr] <= ctl.rdy_value;
      end
   end

endmodule

/* design/register_rename_reorder_buffer.sv */
`timescale 1ns / 1ps

// Register rename map with a circular reorder buffer.
// The req channel carries one transaction per operation: rename, writeback or
// retire. The rsp channel returns one transaction for a rename or writeback and
// one per freed entry for a retire (one with status "not ready" if the head
// cannot retire); last marks the final transaction of each operation.
// A rename or writeback result, and the "not ready" result of a retire, is
// written to the output register once the map and buffer memories have been
// read for the request. A retire that frees entries handles them one at a
// time: for each entry it reads the buffer memory at the head and then the map
// memory at its destination register before it writes that entry's result.
// No new request is taken until the last result of the operation has been
// written to the output register; an unknown operation gives no result, and
// the block stays idle.
// A request may be taken while the previous result still waits in the output
// register; when the receiver stalls, work stops at the next result and holds.
// Reset empties the buffer, drops every mapping and loads rob_entries = 64
// and retire_width = 4. A write of rob_entries through the csr port also
// empties the buffer and the map.
module register_rename_reorder_buffer
   import rrrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_REN   = 5'b00010,
      S_WB    = 5'b00100,
      S_RMAP  = 5'b01000,
      S_REMIT = 5'b10000
   } state_type;

   cfg_type              cfg;
   map_ctl_type          map_ctl;
   map_rd_type           map_rd_a;
   map_rd_type           map_rd_b;
   rob_ctl_type          rob_ctl;
   rob_rd_type           rob_rd;
   logic [ROB_DEPTH-1:0] ready_vec;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [TAG_W-1:0]  head_ff, head_in;
   logic [TAG_W-1:0]  tail_ff, tail_in;
   logic [SIZE_W-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   logic              accept;
   logic              out_free;
   logic              emit;
   rsp_type           res;
   logic [TAG_W-1:0]  head_next;
   logic [TAG_W-1:0]  tail_next;
   logic [SIZE_W-1:0] wb_tag_ext;
   logic [SIZE_W-1:0] head_ext;
   logic [SIZE_W-1:0] wb_offset;
   logic              wb_in_flight;
   logic              ren_has_dest;
   logic              more_to_retire;

   rrrb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rrrb_map u_map (
      .clock (clock),
      .reset (reset),
      .clear (cfg.clear),
      .ctl   (map_ctl),
      .rd_a  (map_rd_a),
      .rd_b  (map_rd_b)
   );

   rrrb_rob u_rob (
      .clock (clock),
      .reset (reset),
      .clear (cfg.clear),
      .ctl   (rob_ctl),
      .rd    (rob_rd),
      .ready (ready_vec)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign head_next = (({1'b0, head_ff} + SIZE_W'(1)) == cfg.size) ? '0 : head_ff + TAG_W'(1);
   assign tail_next = (({1'b0, tail_ff} + SIZE_W'(1)) == cfg.size) ? '0 : tail_ff + TAG_W'(1);

   // A writeback counts only for a tag inside the occupied window.
   assign wb_tag_ext   = {1'b0, req_ff.writeback_tag};
   assign head_ext     = {1'b0, head_ff};
   assign wb_offset    = (wb_tag_ext >= head_ext) ? (wb_tag_ext - head_ext)
                                                  : (wb_tag_ext + cfg.size - head_ext);
   assign wb_in_flight = (wb_tag_ext < cfg.size) && (wb_offset < occ_ff);

   assign ren_has_dest = req_ff.dest_valid && (req_ff.dest_areg < REG_W'(ARCH_REGS));

   // After freeing the head, retirement goes on only if the next head is ready.
   assign more_to_retire = ((cnt_ff + CNT_W'(1)) < cfg.width) && (occ_ff != SIZE_W'(1))
                           && ready_vec[head_next];

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      cnt_in   = cnt_ff;
      emit     = 1'b0;
      res      = '0;
      map_ctl  = '0;
      rob_ctl  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in         = req_payload;
               map_ctl.rd_a   = 1'b1;
               map_ctl.addr_a = req_payload.src1_areg;
               map_ctl.rd_b   = 1'b1;
               map_ctl.addr_b = req_payload.src2_areg;
               rob_ctl.rd      = 1'b1;
               rob_ctl.rd_addr = head_ff;
               cnt_in          = '0;
               case (req_payload.operation)
                  OP_RENAME:    state_in = S_REN;
                  OP_WRITEBACK: state_in = S_WB;
                  OP_RETIRE:    state_in = S_RMAP;
                  default:      state_in = S_IDLE;
               endcase
            end
         end

         S_REN: begin
            if (out_free) begin
               emit     = 1'b1;
               res.last = 1'b1;
               state_in = S_IDLE;
               if (occ_ff >= cfg.size) begin
                  res.status = STATUS_FULL;
               end else begin
                  res.status       = STATUS_DONE;
                  res.entry_tag    = tail_ff;
                  res.src1_renamed = req_ff.src1_valid && map_rd_a.valid;
                  res.src1_ptag    = res.src1_renamed ? map_rd_a.tag : '0;
                  res.src1_rdy     = res.src1_renamed ? ready_vec[map_rd_a.tag] : 1'b1;
                  res.src2_renamed = req_ff.src2_valid && map_rd_b.valid;
                  res.src2_ptag    = res.src2_renamed ? map_rd_b.tag : '0;
                  res.src2_rdy     = res.src2_renamed ? ready_vec[map_rd_b.tag] : 1'b1;

                  rob_ctl.wr        = 1'b1;
                  rob_ctl.wr_addr   = tail_ff;
                  rob_ctl.has_dest  = ren_has_dest;
                  rob_ctl.dest_areg = ren_has_dest ? req_ff.dest_areg : '0;
                  rob_ctl.rdy_en    = 1'b1;
                  rob_ctl.rdy_addr  = tail_ff;
                  rob_ctl.rdy_value = 1'b0;

                  map_ctl.set     = ren_has_dest;
                  map_ctl.wr_addr = req_ff.dest_areg;
                  map_ctl.wr_tag  = tail_ff;

                  tail_in = tail_next;
                  occ_in  = occ_ff + SIZE_W'(1);
               end
            end
         end

         S_WB: begin
            if (out_free) begin
               emit              = 1'b1;
               res.status        = STATUS_DONE;
               res.entry_tag     = req_ff.writeback_tag;
               res.last          = 1'b1;
               rob_ctl.rdy_en    = wb_in_flight;
               rob_ctl.rdy_addr  = req_ff.writeback_tag;
               rob_ctl.rdy_value = 1'b1;
               state_in          = S_IDLE;
            end
         end

         S_RMAP: begin
            if ((cnt_ff == '0) && ((occ_ff == '0) || !ready_vec[head_ff])) begin
               if (out_free) begin
                  emit          = 1'b1;
                  res.status    = STATUS_NOT_READY;
                  res.entry_tag = head_ff;
                  res.last      = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               map_ctl.rd_a   = 1'b1;
               map_ctl.addr_a = rob_rd.dest_areg;
               state_in       = S_REMIT;
            end
         end

         S_REMIT: begin
            if (out_free) begin
               emit                   = 1'b1;
               res.status             = STATUS_DONE;
               res.entry_tag          = head_ff;
               res.retired_dest_valid = rob_rd.has_dest;
               res.retired_dest_areg  = rob_rd.dest_areg;
               res.last               = !more_to_retire;

               // Only the freed entry's own destination can still point at it.
               map_ctl.clr     = rob_rd.has_dest && map_rd_a.valid && (map_rd_a.tag == head_ff);
               map_ctl.wr_addr = rob_rd.dest_areg;

               rob_ctl.rdy_en    = 1'b1;
               rob_ctl.rdy_addr  = head_ff;
               rob_ctl.rdy_value = 1'b0;

               head_in = head_next;
               occ_in  = occ_ff - SIZE_W'(1);
               cnt_in  = cnt_ff + CNT_W'(1);
               if (more_to_retire) begin
                  rob_ctl.rd      = 1'b1;
                  rob_ctl.rd_addr = head_next;
                  state_in        = S_RMAP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = res;
      end else begin
         rsp_valid_in   = rsp_valid_ff && rsp_stall;
         rsp_payload_in = rsp_payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg.clear) begin
            head_ff <= '0;
            tail_ff <= '0;
            occ_ff  <= '0;
         end else begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            occ_ff  <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cfg.size)
      else $error("occupancy exceeds the buffer size");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty buffer with head and tail apart");

   a_retire_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (cnt_ff < cfg.width))
      else $error("retire freed more entries than the retire width");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result was overwritten");

endmodule

/* verif/tb_register_rename_reorder_buffer.sv */
`timescale 1ns / 1ps

module tb_register_rename_reorder_buffer;
   import rrrb_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 182;
   localparam logic [CSR_DATA_W-1:0] ENTRIES_MASK = 32'h7f;
   localparam logic [CSR_DATA_W-1:0] WIDTH_MASK = 32'hf;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_payload;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int send_idle_pct = 36;
   int stall_pct = 36;
   int error_count = 0;
   int quiet_cycles = 0;

   // Shadow copy of the rename map and the reorder buffer.
   logic arch_mapped [ARCH_REGS];
   int unsigned arch_tag [ARCH_REGS];
   logic slot_done [ROB_DEPTH];
   logic slot_has_dest [ROB_DEPTH];
   logic [REG_W-1:0] slot_dest [ROB_DEPTH];
   int unsigned rob_head;
   int unsigned rob_tail;
   int unsigned shadow_occ;
   logic [SIZE_W-1:0] cfg_entries;
   logic [CNT_W-1:0] cfg_width;

   rsp_type pending_results [$];

   register_rename_reorder_buffer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t: %s", $time, msg);
   endfunction

   function automatic string describe_result(input rsp_type r);
      return $sformatf({"status=%0d tag=%0d src1=%0b/%0d/%0b src2=%0b/%0d/%0b",
                        " retired=%0b/%0d last=%0b"},
                       r.status, r.entry_tag, r.src1_renamed, r.src1_ptag, r.src1_rdy,
                       r.src2_renamed, r.src2_ptag, r.src2_rdy, r.retired_dest_valid,
                       r.retired_dest_areg, r.last);
   endfunction

   function automatic int unsigned rob_depth_now();
      if (cfg_entries == 0) return 1;
      if (cfg_entries > ROB_DEPTH) return ROB_DEPTH;
      return cfg_entries;
   endfunction

   function automatic int unsigned retire_limit();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_RETIRE) return MAX_RETIRE;
      return cfg_width;
   endfunction

   function automatic void flush_rob_shadow();
      for (int i = 0; i < ARCH_REGS; i++) begin
         arch_mapped[i] = 1'b0;
         arch_tag[i] = 0;
      end
      for (int i = 0; i < ROB_DEPTH; i++) begin
         slot_done[i] = 1'b0;
         slot_has_dest[i] = 1'b0;
         slot_dest[i] = '0;
      end
      rob_head = 0;
      rob_tail = 0;
      shadow_occ = 0;
   endfunction

   function automatic void lookup_source(input logic valid, input logic [REG_W-1:0] areg,
                                         output logic renamed, output logic [TAG_W-1:0] tag,
                                         output logic ready);
      renamed = 1'b0;
      tag = '0;
      ready = 1'b1;
      if (valid && areg < ARCH_REGS && arch_mapped[areg]) begin
         renamed = 1'b1;
         tag = TAG_W'(arch_tag[areg]);
         ready = slot_done[arch_tag[areg]];
      end
   endfunction

   // Applies one accepted transaction to the shadow state and queues its results.
   function automatic void predict_rob_results(input req_type rq);
      rsp_type r;
      int unsigned depth;
      int unsigned width;
      int unsigned off;
      int unsigned h;
      int unsigned retired;
      logic has_dest;
      depth = rob_depth_now();
      width = retire_limit();
      r = '0;
      r.last = 1'b1;
      case (rq.operation)
         OP_RENAME: begin
            if (shadow_occ >= depth) begin
               r.status = STATUS_FULL;
            end else begin
               // Sources see the map as it was before this destination is written.
               lookup_source(rq.src1_valid, rq.src1_areg, r.src1_renamed, r.src1_ptag,
                             r.src1_rdy);
               lookup_source(rq.src2_valid, rq.src2_areg, r.src2_renamed, r.src2_ptag,
                             r.src2_rdy);
               has_dest = rq.dest_valid && (rq.dest_areg < ARCH_REGS);
               r.entry_tag = TAG_W'(rob_tail);
               slot_done[rob_tail] = 1'b0;
               slot_has_dest[rob_tail] = has_dest;
               slot_dest[rob_tail] = has_dest ? rq.dest_areg : '0;
               if (has_dest) begin
                  arch_mapped[rq.dest_areg] = 1'b1;
                  arch_tag[rq.dest_areg] = rob_tail;
               end
               rob_tail = (rob_tail + 1) % depth;
               shadow_occ++;
            end
            pending_results.push_back(r);
         end
         OP_WRITEBACK: begin
            r.entry_tag = rq.writeback_tag;
            if (rq.writeback_tag < depth) begin
               off = (rq.writeback_tag + depth - rob_head) % depth;
               if (off < shadow_occ) slot_done[rq.writeback_tag] = 1'b1;
            end
            pending_results.push_back(r);
         end
         OP_RETIRE: begin
            if (shadow_occ == 0 || !slot_done[rob_head]) begin
               r.status = STATUS_NOT_READY;
               r.entry_tag = TAG_W'(rob_head);
               pending_results.push_back(r);
            end else begin
               retired = 0;
               while (retired < width && shadow_occ > 0 && slot_done[rob_head]) begin
                  h = rob_head;
                  r = '0;
                  r.entry_tag = TAG_W'(h);
                  r.retired_dest_valid = slot_has_dest[h];
                  r.retired_dest_areg = slot_dest[h];
                  slot_done[h] = 1'b0;
                  if (slot_has_dest[h]) begin
                     for (int i = 0; i < ARCH_REGS; i++) begin
                        if (arch_mapped[i] && arch_tag[i] == h) begin
                           arch_mapped[i] = 1'b0;
                           arch_tag[i] = 0;
                        end
                     end
                  end
                  rob_head = (h + 1) % depth;
                  shadow_occ--;
                  retired++;
                  r.last = !(retired < width && shadow_occ > 0 && slot_done[rob_head]);
                  pending_results.push_back(r);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic [REG_W-1:0] random_arch_reg();
      int unsigned pick;
      pick = $urandom_range(99);
      // A small register set keeps dependencies between instructions frequent.
      if (pick < 55) return REG_W'($urandom_range(7));
      if (pick < 90) return REG_W'($urandom_range(ARCH_REGS - 1));
      return REG_W'($urandom_range(127, ARCH_REGS));
   endfunction

   function automatic req_type random_rename();
      req_type rq;
      rq = req_type'($urandom());
      rq.operation = OP_RENAME;
      rq.dest_valid = ($urandom_range(99) < 85);
      rq.dest_areg = random_arch_reg();
      rq.src1_valid = ($urandom_range(99) < 80);
      rq.src1_areg = random_arch_reg();
      rq.src2_valid = ($urandom_range(99) < 80);
      rq.src2_areg = ($urandom_range(99) < 15) ? rq.dest_areg : random_arch_reg();
      return rq;
   endfunction

   function automatic req_type random_request();
      req_type rq;
      int unsigned pick;
      int unsigned off;
      pick = $urandom_range(99);
      rq = req_type'($urandom());
      if (pick < 42) begin
         rq = random_rename();
      end else if (pick < 75) begin
         rq.operation = OP_WRITEBACK;
         // Mostly complete entries in flight, with a bias toward the head.
         if (shadow_occ > 0 && $urandom_range(99) < 85) begin
            off = ($urandom_range(1) == 0) ? 0 : $urandom_range(shadow_occ - 1);
            rq.writeback_tag = TAG_W'((rob_head + off) % rob_depth_now());
         end
      end else if (pick < 95) begin
         rq.operation = OP_RETIRE;
      end else begin
         rq.operation = OP_UNUSED;
      end
      return rq;
   endfunction

   function automatic req_type make_rename(input logic dv, input int dreg, input logic s1v,
                                           input int s1, input logic s2v, input int s2);
      req_type rq;
      rq = '0;
      rq.operation = OP_RENAME;
      rq.dest_valid = dv;
      rq.dest_areg = REG_W'(dreg);
      rq.src1_valid = s1v;
      rq.src1_areg = REG_W'(s1);
      rq.src2_valid = s2v;
      rq.src2_areg = REG_W'(s2);
      return rq;
   endfunction

   function automatic req_type make_writeback(input int tag);
      req_type rq;
      rq = '0;
      rq.operation = OP_WRITEBACK;
      rq.writeback_tag = TAG_W'(tag);
      return rq;
   endfunction

   function automatic req_type make_retire();
      req_type rq;
      rq = '0;
      rq.operation = OP_RETIRE;
      return rq;
   endfunction

   // The payload stays put while stalled; valid is only lowered when a gap follows.
   task automatic send_request(input req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_rob_results(rq);
   endtask

   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // An ignored operation leaves no result to wait for, so allow the block to finish.
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic sel, input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (sel == REG_ROB_ENTRIES) begin
         cfg_entries = value[SIZE_W-1:0];
         flush_rob_shadow();
      end else begin
         cfg_width = value[CNT_W-1:0];
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic sel, input logic [CSR_DATA_W-1:0] expected);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {sel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== expected)
         flag_error($sformatf("register %0d read %h, expected %h", sel, csr_prdata, expected));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_register(input logic sel, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] mask;
      mask = (sel == REG_ROB_ENTRIES) ? ENTRIES_MASK : WIDTH_MASK;
      wait_for_quiet();
      // Upper data bits carry noise; the register keeps only its own width.
      csr_write(sel, ($urandom() & ~mask) | (value & mask));
      csr_read_check(sel, value & mask);
   endtask

   task automatic test_reset_defaults();
      csr_read_check(REG_ROB_ENTRIES, CSR_DATA_W'(ROB_ENTRIES_RESET));
      csr_read_check(REG_RETIRE_WIDTH, CSR_DATA_W'(RETIRE_WIDTH_RESET));
   endtask

   task automatic test_rename_paths();
      req_type junk;
      junk = '1;
      send_request(make_retire());
      send_request(make_rename(1'b1, 0, 1'b1, 0, 1'b1, 0));
      send_request(make_rename(1'b1, 66, 1'b1, 0, 1'b1, 66));
      send_request(make_rename(1'b1, 66, 1'b1, 66, 1'b1, 66));
      // A source marked invalid is not looked up even when its register is mapped.
      send_request(make_rename(1'b0, 5, 1'b0, 0, 1'b1, 127));
      send_request(make_rename(1'b1, 67, 1'b1, 67, 1'b1, 66));
      send_request(make_rename(1'b1, 127, 1'b1, 127, 1'b1, 5));
      send_request(make_retire());
      send_request(make_writeback(63));
      send_request(make_writeback(0));
      send_request(make_writeback(1));
      send_request(make_writeback(2));
      send_request(make_writeback(4));
      send_request(make_rename(1'b1, 1, 1'b1, 0, 1'b1, 66));
      send_request(make_retire());
      send_request(make_retire());
      send_request(make_writeback(3));
      send_request(make_writeback(5));
      send_request(make_writeback(6));
      send_request(make_retire());
      send_request(make_writeback(2));
      send_request(junk);
   endtask

   task automatic test_buffer_limits();
      program_register(REG_ROB_ENTRIES, 1);
      program_register(REG_RETIRE_WIDTH, 0);
      send_request(make_rename(1'b1, 3, 1'b1, 3, 1'b0, 0));
      send_request(make_rename(1'b1, 4, 1'b1, 3, 1'b1, 4));
      send_request(make_retire());
      send_request(make_writeback(0));
      send_request(make_writeback(1));
      send_request(make_rename(1'b1, 3, 1'b0, 0, 1'b0, 0));
      send_request(make_retire());
      send_request(make_rename(1'b1, 3, 1'b1, 3, 1'b0, 0));
      // Rewriting the size drops the entry still in flight.
      program_register(REG_ROB_ENTRIES, 0);
      send_request(make_rename(1'b1, 3, 1'b1, 3, 1'b0, 0));
      send_request(make_rename(1'b1, 9, 1'b1, 3, 1'b0, 0));

      program_register(REG_ROB_ENTRIES, 127);
      program_register(REG_RETIRE_WIDTH, 15);
      repeat (ROB_DEPTH + 1) send_request(random_rename());
      for (int t = ROB_DEPTH - 1; t >= 0; t--) send_request(make_writeback(t));
      repeat (ROB_DEPTH / MAX_RETIRE + 1) send_request(make_retire());

      program_register(REG_ROB_ENTRIES, 2);
      program_register(REG_RETIRE_WIDTH, 8);
      send_request(make_rename(1'b1, 10, 1'b0, 0, 1'b0, 0));
      send_request(make_rename(1'b1, 10, 1'b1, 10, 1'b0, 0));
      send_request(make_rename(1'b1, 11, 1'b1, 10, 1'b0, 0));
      send_request(make_writeback(1));
      send_request(make_retire());
      send_request(make_writeback(0));
      send_request(make_retire());
      send_request(make_rename(1'b1, 10, 1'b1, 10, 1'b0, 0));
      send_request(make_writeback(0));
      send_request(make_rename(1'b1, 12, 1'b1, 10, 1'b0, 0));
      send_request(make_retire());
   endtask

   task automatic test_random_traffic();
      int unsigned sizes [7] = '{8, 127, 0, 5, 64, 33, 16};
      int unsigned widths [7] = '{2, 15, 0, 8, 1, 3, 9};
      int per_phase;
      int sent;
      req_type rq;
      per_phase = RANDOM_ITEMS / 7;
      for (int ph = 0; ph < 7; ph++) begin
         program_register(REG_ROB_ENTRIES, sizes[ph]);
         program_register(REG_RETIRE_WIDTH, widths[ph]);
         // One phase runs back to back with neither side holding off.
         send_idle_pct = (ph == 4) ? 0 : 36;
         stall_pct = (ph == 4) ? 0 : 36;
         sent = 0;
         while (sent < per_phase) begin
            rq = random_request();
            send_request(rq);
            if (rq.operation != OP_UNUSED) sent++;
            if (ph == 2 && sent == per_phase / 2) wait_for_quiet();
         end
      end
      send_idle_pct = 36;
      stall_pct = 36;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            flag_error($sformatf("unexpected result %s", describe_result(rsp_payload)));
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.status !== want.status ||
                rsp_payload.entry_tag !== want.entry_tag ||
                rsp_payload.src1_renamed !== want.src1_renamed ||
                rsp_payload.src1_ptag !== want.src1_ptag ||
                rsp_payload.src1_rdy !== want.src1_rdy ||
                rsp_payload.src2_renamed !== want.src2_renamed ||
                rsp_payload.src2_ptag !== want.src2_ptag ||
                rsp_payload.src2_rdy !== want.src2_rdy ||
                rsp_payload.retired_dest_valid !== want.retired_dest_valid ||
                rsp_payload.retired_dest_areg !== want.retired_dest_areg ||
                rsp_payload.last !== want.last)
               flag_error($sformatf("result mismatch\n   expected %s\n   actual   %s",
                                    describe_result(want), describe_result(rsp_payload)));
         end
      end
   end

   // Ends the run when no transaction of any kind has moved for too long.
   always @(posedge clock) begin
      if (reset || csr_psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      cfg_entries = ROB_ENTRIES_RESET;
      cfg_width = RETIRE_WIDTH_RESET;
      flush_rob_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_rename_paths();
      test_buffer_limits();
      test_random_traffic();
      wait_for_quiet();
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
